// ===== hdl/ljb_pkg.sv =====
// Shared types and constants for the Ljung-Box Q statistic block.
// Used by ljb_front, ljb_back, ljb_check and the top level; depends on nothing else.
package ljb_pkg;

    // Default sizing of the return store and the number of lags.
    localparam int unsigned DEF_MAX_RETURNS = 1024;
    localparam int unsigned DEF_NUM_LAGS    = 5;

    // Depth of the command queue between front and back end (power of two).
    localparam int unsigned QUEUE_DEPTH = 4;

    // ln(2) in Q0.30.
    localparam logic [31:0] LN2_Q30 = 32'd744261118;

    // Products of deviations drop this many fraction bits.
    localparam int unsigned PROD_SHIFT = 16;

    // One classified price word handed from the front end to the back end.
    typedef struct packed {
        logic [31:0] price;
        logic        last;
        logic        form;      // pairs with the previous price into a return
        logic        need_log;  // log2 of this price is needed now or later
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOG_WAIT,
        ST_LR_LO,
        ST_LR_HI,
        ST_LR_SUM,
        ST_LR_WR,
        ST_TAIL,
        ST_CHECK,
        ST_MEAN_WAIT,
        ST_RD,
        ST_DEV,
        ST_MUL,
        ST_ACC,
        ST_PASS_END,
        ST_NORM,
        ST_RHO_WAIT,
        ST_RHO_SQ,
        ST_TERM_DIV,
        ST_TERM_WAIT,
        ST_M_MUL,
        ST_M_LAT,
        ST_Q_MUL,
        ST_Q_ADD,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/ljb_front.sv =====
// Front end: accepts price words, classifies them and queues commands.
// Depends on ljb_pkg for the command type and the queue depth.
module ljb_front
    import ljb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_price,
    input  logic        i_last,
    output logic        o_stall,
    output t_cmd        o_cmd,
    output logic        o_cmd_valid,
    input  logic        i_cmd_pop
);

    localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

    t_cmd             r_queue [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_count;
    logic             r_prev_ok;

    logic             w_accept;
    logic             w_pop;
    logic             w_form;
    t_cmd             w_cmd;

    assign o_stall     = (r_count == (QAW + 1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd];
    assign w_accept    = i_valid && !o_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    // Classify the incoming word against the previous price of the series.
    always_comb begin
        w_form         = r_prev_ok && (i_price != '0);
        w_cmd.price    = i_price;
        w_cmd.last     = i_last;
        w_cmd.form     = w_form;
        w_cmd.need_log = (i_price != '0) && (w_form || !i_last);
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_queue[r_wr] <= w_cmd;
        end
    end

    // Pointers, fill count and the previous-price flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_count   <= '0;
            r_prev_ok <= 1'b0;
        end else begin
            if (w_accept) begin
                r_wr      <= r_wr + QAW'(1);
                r_prev_ok <= !i_last && (i_price != '0);
            end
            if (w_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({w_accept, w_pop})
                2'b10:   r_count <= r_count + (QAW + 1)'(1);
                2'b01:   r_count <= r_count - (QAW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/ljb_log.sv =====
// Iterative log2 unit: result in Q5.28 for a nonzero 32-bit input.
// Depends on nothing but the clock; five normalize steps, then 28 squarings.
module ljb_log (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    output logic        o_done,
    output logic [32:0] o_log
);

    logic [31:0] r_y;
    logic [4:0]  r_e;
    logic [27:0] r_frac;
    logic [5:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [5:0]  w_sh;
    logic        w_top_zero;
    logic [63:0] w_sq;
    logic [32:0] w_sq_sh;

    assign o_done = r_done;
    assign o_log  = {r_e, r_frac};

    // Binary search for the leading one: shift by 16, 8, 4, 2, 1.
    always_comb begin
        case (r_step)
            6'd0:    w_sh = 6'd16;
            6'd1:    w_sh = 6'd8;
            6'd2:    w_sh = 6'd4;
            6'd3:    w_sh = 6'd2;
            6'd4:    w_sh = 6'd1;
            default: w_sh = 6'd0;
        endcase
        w_top_zero = ((r_y >> (6'd32 - w_sh)) == '0);
        w_sq       = r_y * r_y;
        w_sq_sh    = w_sq[63:31];
    end

    // One normalize or squaring step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_step == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_y    <= i_x;
            r_e    <= 5'd31;
            r_frac <= '0;
        end else if (r_busy) begin
            if (r_step < 6'd5) begin
                if (w_top_zero) begin
                    r_y <= r_y << w_sh;
                    r_e <= r_e - w_sh[4:0];
                end
            end else begin
                r_frac <= {r_frac[26:0], w_sq_sh[32]};
                r_y    <= w_sq_sh[32] ? w_sq_sh[32:1] : w_sq_sh[31:0];
            end
        end
    end

endmodule

// ===== hdl/ljb_div.sv =====
// Restoring divider: 64-bit dividend by nonzero 32-bit divisor, one bit a cycle.
// Depends on nothing but the clock; the quotient holds until the next start.
module ljb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dsr;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] w_rem_sh;
    logic        w_ge;
    logic [32:0] w_rem_sub;

    assign o_done = r_done;
    assign o_quot = r_quo;

    // Shift in the next dividend bit and try to subtract.
    always_comb begin
        w_rem_sh  = {r_rem, r_quo[63]};
        w_ge      = (w_rem_sh >= {1'b0, r_dsr});
        w_rem_sub = w_rem_sh - {1'b0, r_dsr};
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[31:0] : w_rem_sh[31:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

endmodule

// ===== hdl/ljb_back.sv =====
// Back end: turns queued prices into stored log returns and computes Q.
// Depends on ljb_pkg, ljb_log and ljb_div.
module ljb_back
    import ljb_pkg::*;
#(
    parameter int unsigned MAX_RETURNS = DEF_MAX_RETURNS,
    parameter int unsigned NUM_LAGS    = DEF_NUM_LAGS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_q_stat,
    output logic        o_q_valid,
    output logic [10:0] o_return_count
);

    localparam int unsigned AW = $clog2(MAX_RETURNS);
    localparam int unsigned CW = $clog2(MAX_RETURNS + 1);
    localparam int unsigned KW = $clog2(NUM_LAGS + 1);

    // Return store.
    logic [31:0]        r_mem [MAX_RETURNS];
    logic [31:0]        r_rd_a;
    logic [31:0]        r_rd_b;

    t_state             r_state;
    t_state             n_state;
    t_cmd               r_cmd;

    // Series state.
    logic [CW-1:0]      r_cnt;
    logic               r_overflow;
    logic signed [63:0] r_sum;
    logic [32:0]        r_prev_log;

    // Log return datapath.
    logic [32:0]        r_mag;
    logic               r_neg;
    logic [63:0]        r_lr;
    logic [63:0]        r_prod;

    // Finish datapath.
    logic signed [32:0] r_mean;
    logic [AW-1:0]      r_t;
    logic [KW-1:0]      r_k;
    logic signed [31:0] r_dev_a;
    logic signed [31:0] r_dev_b;
    logic               r_pneg;
    logic signed [63:0] r_acc;
    logic [63:0]        r_dn;
    logic [5:0]         r_s;
    logic [31:0]        r_rho;
    logic [63:0]        r_qacc;
    logic [33:0]        r_m;
    logic [1:0]         r_j;
    logic [97:0]        r_big;
    logic               r_qv;

    // Output register.
    logic               r_out_valid;
    logic [31:0]        r_out_q;
    logic               r_out_qv;
    logic [10:0]        r_out_cnt;

    // Unit connections and sequencer outputs.
    logic               w_log_start;
    logic               w_log_done;
    logic [32:0]        w_log;
    logic               w_div_start;
    logic [63:0]        w_div_dvd;
    logic [31:0]        w_div_dsr;
    logic               w_div_done;
    logic [63:0]        w_quot;
    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [63:0]        w_mul_p;
    logic               w_mem_we;
    logic               w_out_free;

    // Helper values.
    logic [33:0]        w_diff;
    logic [33:0]        w_diff_neg;
    logic [33:0]        w_rmag;
    logic [31:0]        w_ret;
    logic [63:0]        w_smag;
    logic               w_full;
    logic               w_invalid;
    logic [AW-1:0]      w_addr_b;
    logic signed [33:0] w_da;
    logic signed [33:0] w_db;
    logic [31:0]        w_sat_a;
    logic [31:0]        w_sat_b;
    logic [31:0]        w_abs_a;
    logic [31:0]        w_abs_b;
    logic [63:0]        w_pshift;
    logic [63:0]        w_nm;
    logic [63:0]        w_nm_sh;
    logic [31:0]        w_nm32;
    logic               w_last_t;
    logic [KW-1:0]      w_k_next;
    logic [97:0]        w_part;

    ljb_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_log_start),
        .i_x     (i_cmd.price),
        .o_done  (w_log_done),
        .o_log   (w_log)
    );

    ljb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_valid        = r_out_valid;
    assign o_q_stat       = r_out_q;
    assign o_q_valid      = r_out_qv;
    assign o_return_count = r_out_cnt;
    assign w_out_free     = !r_out_valid || !i_stall;
    assign w_mul_p        = w_mul_a * w_mul_b;

    // Log return: scale the log2 difference by ln2 and saturate.
    always_comb begin
        w_diff     = {1'b0, w_log} - {1'b0, r_prev_log};
        w_diff_neg = -w_diff;
        w_rmag     = r_lr[63:30];
        if (r_neg) begin
            w_ret = (w_rmag > 34'h080000000) ? 32'h80000000 : 32'(-w_rmag);
        end else begin
            w_ret = (w_rmag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : w_rmag[31:0];
        end
        w_smag    = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
        w_full    = (r_cnt == CW'(MAX_RETURNS));
        w_invalid = r_overflow || (32'(r_cnt) < 32'(NUM_LAGS + 2));
    end

    // Deviations from the mean, saturated, and their magnitudes.
    always_comb begin
        w_addr_b = r_t - AW'(r_k);
        w_da     = $signed({{2{r_rd_a[31]}}, r_rd_a}) - $signed({r_mean[32], r_mean});
        w_db     = $signed({{2{r_rd_b[31]}}, r_rd_b}) - $signed({r_mean[32], r_mean});
        if (w_da[33:31] == 3'b000 || w_da[33:31] == 3'b111) begin
            w_sat_a = w_da[31:0];
        end else begin
            w_sat_a = w_da[33] ? 32'h80000000 : 32'h7FFFFFFF;
        end
        if (w_db[33:31] == 3'b000 || w_db[33:31] == 3'b111) begin
            w_sat_b = w_db[31:0];
        end else begin
            w_sat_b = w_db[33] ? 32'h80000000 : 32'h7FFFFFFF;
        end
        w_abs_a  = r_dev_a[31] ? 32'(-r_dev_a) : 32'(r_dev_a);
        w_abs_b  = r_dev_b[31] ? 32'(-r_dev_b) : 32'(r_dev_b);
        w_pshift = r_prod >> PROD_SHIFT;
        w_last_t = (CW'(r_t) == (r_cnt - CW'(1)));
        w_k_next = r_k + KW'(1);
    end

    // Correlation numerator scaled alongside the denominator.
    always_comb begin
        w_nm    = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
        w_nm_sh = w_nm >> r_s;
        w_nm32  = (w_nm_sh[63:32] != '0) ? 32'hFFFFFFFF : w_nm_sh[31:0];
    end

    // Partial product of n(n+2) times the sum of terms, placed by its weight.
    always_comb begin
        case (r_j)
            2'd0:    w_part = 98'(r_prod);
            2'd1:    w_part = 98'(r_prod) << 17;
            2'd2:    w_part = 98'(r_prod) << 32;
            2'd3:    w_part = 98'(r_prod) << 49;
            default: w_part = '0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.need_log ? ST_LOG_WAIT : ST_TAIL;
                end
            end
            ST_LOG_WAIT: begin
                if (w_log_done) begin
                    n_state = (r_cmd.form && !w_full) ? ST_LR_LO : ST_TAIL;
                end
            end
            ST_LR_LO:  n_state = ST_LR_HI;
            ST_LR_HI:  n_state = ST_LR_SUM;
            ST_LR_SUM: n_state = ST_LR_WR;
            ST_LR_WR:  n_state = ST_TAIL;
            ST_TAIL:   n_state = r_cmd.last ? ST_CHECK : ST_IDLE;
            ST_CHECK:  n_state = w_invalid ? ST_OUT : ST_MEAN_WAIT;
            ST_MEAN_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:  n_state = ST_DEV;
            ST_DEV: n_state = ST_MUL;
            ST_MUL: n_state = ST_ACC;
            ST_ACC: n_state = w_last_t ? ST_PASS_END : ST_RD;
            ST_PASS_END: begin
                if (r_k != '0) begin
                    n_state = ST_RHO_WAIT;
                end else if (r_acc == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (r_dn[63:31] == '0) begin
                    n_state = ST_RD;
                end
            end
            ST_RHO_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_RHO_SQ;
                end
            end
            ST_RHO_SQ:   n_state = ST_TERM_DIV;
            ST_TERM_DIV: n_state = ST_TERM_WAIT;
            ST_TERM_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_k == KW'(NUM_LAGS)) ? ST_M_MUL : ST_RD;
                end
            end
            ST_M_MUL: n_state = ST_M_LAT;
            ST_M_LAT: n_state = ST_Q_MUL;
            ST_Q_MUL: n_state = ST_Q_ADD;
            ST_Q_ADD: n_state = (r_j == 2'd3) ? ST_OUT : ST_Q_MUL;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: unit starts, operands and store write.
    always_comb begin
        o_cmd_pop   = 1'b0;
        w_log_start = 1'b0;
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        w_div_dsr   = 32'd1;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_mem_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_pop   = i_cmd_valid;
                w_log_start = i_cmd_valid && i_cmd.need_log;
            end
            ST_LR_LO: begin
                w_mul_a = {15'b0, r_mag[16:0]};
                w_mul_b = LN2_Q30;
            end
            ST_LR_HI: begin
                w_mul_a = {16'b0, r_mag[32:17]};
                w_mul_b = LN2_Q30;
            end
            ST_LR_WR: begin
                w_mem_we = 1'b1;
            end
            ST_CHECK: begin
                w_div_start = !w_invalid;
                w_div_dvd   = w_smag + 64'(r_cnt >> 1);
                w_div_dsr   = 32'(r_cnt);
            end
            ST_MUL: begin
                w_mul_a = w_abs_a;
                w_mul_b = w_abs_b;
            end
            ST_PASS_END: begin
                w_div_start = (r_k != '0);
                w_div_dvd   = {2'b00, w_nm32, 30'b0};
                w_div_dsr   = r_dn[31:0];
            end
            ST_RHO_SQ: begin
                w_mul_a = r_rho;
                w_mul_b = r_rho;
            end
            ST_TERM_DIV: begin
                w_div_start = 1'b1;
                w_div_dvd   = r_prod >> 28;
                w_div_dsr   = 32'(r_cnt) - 32'(r_k);
            end
            ST_M_MUL: begin
                w_mul_a = 32'(r_cnt);
                w_mul_b = 32'(r_cnt) + 32'd2;
            end
            ST_Q_MUL: begin
                w_mul_a = r_j[0] ? {15'b0, r_m[33:17]} : {15'b0, r_m[16:0]};
                w_mul_b = r_j[1] ? r_qacc[63:32] : r_qacc[31:0];
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    // Store write and the two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_cnt[AW-1:0]] <= w_ret;
        end
        r_rd_a <= r_mem[r_t];
        r_rd_b <= r_mem[w_addr_b];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_overflow  <= 1'b0;
            r_sum       <= '0;
            r_qacc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOG_WAIT: begin
                    if (w_log_done && r_cmd.form && w_full) begin
                        r_overflow <= 1'b1;
                    end
                end
                ST_LR_WR: begin
                    r_cnt <= r_cnt + CW'(1);
                    r_sum <= r_sum + 64'($signed(w_ret));
                end
                ST_PASS_END: begin
                    if (r_k == '0) begin
                        r_qacc <= '0;
                    end
                end
                ST_TERM_WAIT: begin
                    if (w_div_done) begin
                        r_qacc <= r_qacc + w_quot;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_cnt       <= '0;
                        r_overflow  <= 1'b0;
                        r_sum       <= '0;
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                end
            end
            ST_LOG_WAIT: begin
                if (w_log_done) begin
                    r_prev_log <= w_log;
                    r_neg      <= w_diff[33];
                    r_mag      <= w_diff[33] ? w_diff_neg[32:0] : w_diff[32:0];
                end
            end
            ST_LR_HI:  r_lr <= r_prod + 64'h20000000;
            ST_LR_SUM: r_lr <= r_lr + (r_prod << 17);
            ST_CHECK:  r_qv <= !w_invalid;
            ST_MEAN_WAIT: begin
                if (w_div_done) begin
                    r_mean <= r_sum[63] ? -$signed({1'b0, w_quot[31:0]})
                                        : $signed({1'b0, w_quot[31:0]});
                    r_k    <= '0;
                    r_t    <= '0;
                    r_acc  <= '0;
                end
            end
            ST_DEV: begin
                r_dev_a <= w_sat_a;
                r_dev_b <= w_sat_b;
            end
            ST_MUL: r_pneg <= r_dev_a[31] ^ r_dev_b[31];
            ST_ACC: begin
                r_acc <= r_pneg ? r_acc - $signed(w_pshift) : r_acc + $signed(w_pshift);
                if (!w_last_t) begin
                    r_t <= r_t + AW'(1);
                end
            end
            ST_PASS_END: begin
                if (r_k == '0) begin
                    r_qv <= (r_acc != '0);
                    r_dn <= r_acc;
                    r_s  <= '0;
                end
            end
            ST_NORM: begin
                if (r_dn[63:31] != '0) begin
                    r_dn <= r_dn >> 1;
                    r_s  <= r_s + 6'd1;
                end else begin
                    r_k   <= KW'(1);
                    r_t   <= AW'(1);
                    r_acc <= '0;
                end
            end
            ST_RHO_WAIT: begin
                if (w_div_done) begin
                    r_rho <= (w_quot > 64'h80000000) ? 32'h80000000 : w_quot[31:0];
                end
            end
            ST_TERM_WAIT: begin
                if (w_div_done && r_k != KW'(NUM_LAGS)) begin
                    r_k   <= w_k_next;
                    r_t   <= AW'(w_k_next);
                    r_acc <= '0;
                end
            end
            ST_M_LAT: begin
                r_m   <= r_prod[33:0];
                r_j   <= '0;
                r_big <= '0;
            end
            ST_Q_ADD: begin
                r_big <= r_big + w_part;
                r_j   <= r_j + 2'd1;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_out_qv  <= r_qv;
                    r_out_cnt <= 11'(r_cnt);
                    if (!r_qv) begin
                        r_out_q <= '0;
                    end else if (r_big[97:48] != '0) begin
                        r_out_q <= 32'hFFFFFFFF;
                    end else begin
                        r_out_q <= r_big[47:16];
                    end
                end
            end
            default: begin
                r_lr <= r_lr;
            end
        endcase
    end

endmodule

// ===== hdl/ljung_box_q_log_returns.sv =====
// Ljung-Box Q over the log returns of a price series. Each accepted word
// carries one price; the word marked last closes the series and produces one
// result word with Q in unsigned Q16.16, a valid flag and the number of
// returns. A price that forms a return passes in the back end through the
// iterative log2 unit, then the ln2 scaling and the store write; a zero
// price skips the log2 unit. The front queue holds up to four words, so
// input is taken while the back end works. After the last price the
// sequencer makes NUM_LAGS+1 passes over the return store, each element
// going through the shared multiplier, and runs the 1+2*NUM_LAGS divisions
// in the serial divider. Results of fewer than NUM_LAGS+2 returns, of more
// returns than the store holds or of zero variance come out with the valid
// flag low and Q zero.
// Depends on ljb_pkg, ljb_front and ljb_back.
module ljung_box_q_log_returns
    import ljb_pkg::*;
#(
    parameter int unsigned MAX_RETURNS = DEF_MAX_RETURNS,
    parameter int unsigned NUM_LAGS    = DEF_NUM_LAGS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_price,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_q_stat,
    output logic        o_q_valid,
    output logic [10:0] o_return_count
);

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;

    // Front end: classify prices and queue them.
    ljb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_price     (i_price),
        .i_last      (i_last),
        .o_stall     (o_stall),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Back end: returns, statistics and the result register.
    ljb_back #(
        .MAX_RETURNS (MAX_RETURNS),
        .NUM_LAGS    (NUM_LAGS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_pop      (w_cmd_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_q_stat       (o_q_stat),
        .o_q_valid      (o_q_valid),
        .o_return_count (o_return_count)
    );

endmodule

// ===== hdl/ljb_check.sv =====
// Port-level checks for the Ljung-Box Q block and their bind to the top level.
// Depends on ljb_pkg and the top-level module ljung_box_q_log_returns.
module ljb_check
    import ljb_pkg::*;
#(
    parameter int unsigned MAX_RETURNS = DEF_MAX_RETURNS,
    parameter int unsigned NUM_LAGS    = DEF_NUM_LAGS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_q_stat,
    input logic        o_q_valid,
    input logic [10:0] o_return_count
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_q_stat) && $stable(o_q_valid)
                               && $stable(o_return_count))
        else $error("result word changed while stalled");

    // An undefined statistic reads as zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_q_valid |-> o_q_stat == 32'd0)
        else $error("invalid result carries a nonzero statistic");

    // A defined statistic needs enough returns and never more than the store holds.
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_q_valid |-> (MAX_RETURNS > 2047)
            || ((32'(o_return_count) >= NUM_LAGS + 2)
                && (32'(o_return_count) <= MAX_RETURNS)))
        else $error("valid result with an impossible return count");

    // Reset empties the result register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

endmodule

bind ljung_box_q_log_returns ljb_check #(
    .MAX_RETURNS (MAX_RETURNS),
    .NUM_LAGS    (NUM_LAGS)
) u_ljb_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_q_stat       (o_q_stat),
    .o_q_valid      (o_q_valid),
    .o_return_count (o_return_count)
);
